[rtl/gregorian_date_add_subtract_days_defines.svh]
// Assertion helpers used by the top-level RTL.
`ifndef GREGORIAN_DATE_ADD_SUBTRACT_DAYS_DEFINES_SVH
`define GREGORIAN_DATE_ADD_SUBTRACT_DAYS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GDAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GDAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gdas_pkg.sv]
`default_nettype none
package gdas_pkg;

  localparam int unsigned DAY_W       = 5;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned YEAR_IN_W   = 14;
  localparam int unsigned DAY_COUNT_W = 16;
  // walk year: start year plus or minus the span of the largest count
  localparam int unsigned YEAR_W      = 16;
  localparam int unsigned REM_W       = 9;

  localparam int unsigned LEAP_CYCLE  = 400;
  localparam int unsigned CENTURY     = 100;
  localparam int unsigned YEAR_MIN    = 1;
  localparam int unsigned YEAR_MAX    = 9999;

  localparam int unsigned REDUCE_STEPS = 6;
  localparam int unsigned RED_IDX_W    = $clog2(REDUCE_STEPS);

  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] APR = 4'd4;
  localparam logic [MONTH_W-1:0] JUN = 4'd6;
  localparam logic [MONTH_W-1:0] SEP = 4'd9;
  localparam logic [MONTH_W-1:0] NOV = 4'd11;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_WRAP = 4'd13;

  localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
  localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
  localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;

  typedef struct packed {
    logic                 mode;
    logic [DAY_W-1:0]     start_day;
    logic [MONTH_W-1:0]   start_month;
    logic [YEAR_IN_W-1:0] start_year;
    logic [DAY_COUNT_W-1:0] day_count;
  } item_t;

  typedef struct packed {
    logic [DAY_W-1:0]     result_day;
    logic [MONTH_W-1:0]   result_month;
    logic [YEAR_IN_W-1:0] result_year;
    logic                 out_of_range;
  } result_t;

  typedef struct packed {
    logic                 load;
    logic                 reduce;
    logic [RED_IDX_W-1:0] red_idx;
    logic                 norm;
    logic                 step;
    logic                 load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } dp_status_t;

  // rem is the year modulo 400
  function automatic logic is_leap(input logic [REM_W-1:0] rem);
    logic century;
    century = (rem == REM_W'(CENTURY)) || (rem == REM_W'(2 * CENTURY)) ||
              (rem == REM_W'(3 * CENTURY));
    return (rem == '0) || ((rem[1:0] == 2'b00) && !century);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      FEB:                len = leap ? LEN_LEAP : LEN_FEB;
      APR, JUN, SEP, NOV: len = LEN_SHORT;
      default:            len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[rtl/gdas_item_if.sv]
`default_nettype none
interface gdas_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [13:0] start_year;
  logic [15:0] day_count;

  modport source (output valid, mode, start_day, start_month, start_year, day_count,
                  input ready);
  modport sink (input valid, mode, start_day, start_month, start_year, day_count,
                output ready);
endinterface
`default_nettype wire

[rtl/gdas_result_if.sv]
`default_nettype none
interface gdas_result_if;
  logic        valid;
  logic        ready;
  logic [4:0]  result_day;
  logic [3:0]  result_month;
  logic [13:0] result_year;
  logic        out_of_range;

  modport source (output valid, result_day, result_month, result_year, out_of_range,
                  input ready);
  modport sink (input valid, result_day, result_month, result_year, out_of_range,
                output ready);
endinterface
`default_nettype wire

[rtl/gdas_ctrl.sv]
`default_nettype none
module gdas_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  gdas_pkg::dp_status_t status,
  output gdas_pkg::dp_cmd_t    cmd
);
  import gdas_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    REDUCE,
    NORM,
    WALK
  } state_t;

  state_t               state;
  logic [RED_IDX_W-1:0] red_idx;

  assign item_ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.red_idx  = red_idx;
    case (state)
      IDLE:    cmd.load = item_valid;
      REDUCE:  cmd.reduce = 1'b1;
      NORM:    cmd.norm = 1'b1;
      WALK: begin
        cmd.step     = !status.walk_done;
        cmd.load_out = status.walk_done && status.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      red_idx <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (item_valid) begin
            state   <= REDUCE;
            red_idx <= RED_IDX_W'(REDUCE_STEPS - 1);
          end
        end
        REDUCE: begin
          if (red_idx == '0) begin
            state <= NORM;
          end else begin
            red_idx <= red_idx - 1'b1;
          end
        end
        NORM: state <= WALK;
        WALK: begin
          if (status.walk_done && status.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/gdas_datapath.sv]
`default_nettype none
module gdas_datapath #(
  parameter int COUNT_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  gdas_pkg::item_t      item,
  input  gdas_pkg::dp_cmd_t    cmd,
  output gdas_pkg::dp_status_t status,
  output gdas_pkg::result_t    result,
  output logic                 result_valid,
  input  wire                  result_ready
);
  import gdas_pkg::*;

  localparam int CW = (COUNT_BITS < DAY_COUNT_W) ? COUNT_BITS : DAY_COUNT_W;
  localparam int KW = ((CW > DAY_W) ? CW : DAY_W) + 1;

  logic                     sub;
  logic [DAY_W-1:0]         day;
  logic [MONTH_W-1:0]       month;
  logic signed [YEAR_W-1:0] year;
  logic [YEAR_IN_W-1:0]     yrem;
  // remaining days: running day-of-walk when adding, count left when subtracting
  logic [KW-1:0]            k;

  logic [REM_W-1:0]     rem;
  logic [DAY_W-1:0]     len;
  logic [YEAR_IN_W-1:0] red_sub;
  logic [DAY_W-1:0]     day_clamped;
  logic [MONTH_W-1:0]   month_inc;
  logic [MONTH_W-1:0]   month_dec;
  logic [REM_W-1:0]     rem_inc;
  logic [REM_W-1:0]     rem_dec;
  logic                 wrap_up;
  logic                 wrap_down;
  logic [DAY_W-1:0]     len_prev;
  logic                 done_add;
  logic                 done_sub;
  logic [DAY_W-1:0]     day_out;
  logic [YEAR_IN_W-1:0] year_out;
  logic                 flag_out;

  assign rem         = yrem[REM_W-1:0];
  assign len         = month_len(month, is_leap(rem));
  assign red_sub     = YEAR_IN_W'(LEAP_CYCLE) << cmd.red_idx;
  assign day_clamped = (day > len) ? len : day;

  assign month_inc = month + 1'b1;
  assign month_dec = month - 1'b1;
  assign wrap_up   = (month_inc == MONTH_WRAP);
  assign wrap_down = (month_dec == '0);
  assign rem_inc   = (rem == REM_W'(LEAP_CYCLE - 1)) ? '0 : rem + 1'b1;
  assign rem_dec   = (rem == '0) ? REM_W'(LEAP_CYCLE - 1) : rem - 1'b1;
  assign len_prev  = wrap_down ? month_len(DEC, is_leap(rem_dec))
                               : month_len(month_dec, is_leap(rem));

  assign done_add = (k <= KW'(len));
  assign done_sub = (KW'(day) > k);

  assign status.walk_done = sub ? done_sub : done_add;
  assign status.out_free  = !result_valid || result_ready;

  assign day_out = sub ? (day - k[DAY_W-1:0]) : k[DAY_W-1:0];

  always_comb begin
    flag_out = 1'b1;
    if (year < YEAR_W'(signed'(YEAR_MIN))) begin
      year_out = YEAR_IN_W'(YEAR_MIN);
    end else if (year > YEAR_W'(signed'(YEAR_MAX))) begin
      year_out = YEAR_IN_W'(YEAR_MAX);
    end else begin
      year_out = year[YEAR_IN_W-1:0];
      flag_out = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sub   <= item.mode;
      day   <= (item.start_day == '0) ? DAY_W'(1) : item.start_day;
      month <= (item.start_month == '0) ? JAN :
               (item.start_month > DEC) ? DEC : item.start_month;
      year  <= signed'(YEAR_W'(item.start_year));
      yrem  <= item.start_year;
      k     <= KW'(item.day_count[CW-1:0]);
    end
    if (cmd.reduce && (yrem >= red_sub)) begin
      yrem <= yrem - red_sub;
    end
    if (cmd.norm) begin
      day <= day_clamped;
      if (!sub) begin
        k <= k + KW'(day_clamped);
      end
    end
    if (cmd.step) begin
      if (!sub) begin
        k     <= k - KW'(len);
        month <= wrap_up ? JAN : month_inc;
        if (wrap_up) begin
          year <= year + 1'b1;
          yrem <= YEAR_IN_W'(rem_inc);
        end
      end else begin
        k     <= k - KW'(day);
        day   <= len_prev;
        month <= wrap_down ? DEC : month_dec;
        if (wrap_down) begin
          year <= year - 1'b1;
          yrem <= YEAR_IN_W'(rem_dec);
        end
      end
    end
    if (cmd.load_out) begin
      result.result_day   <= day_out;
      result.result_month <= month;
      result.result_year  <= year_out;
      result.out_of_range <= flag_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/gregorian_date_add_subtract_days.sv]
// From the item transaction to the result an item passes through these steps in order:
// 1 load, 6 year-mod-400 reduction steps, 1 day clamp, the month walk, 1 final result load.
// The block takes one item at a time; the month walk advances one month per cycle, and the
// final result load waits until the output register is free.
// The next item is taken while a finished result still waits in the output register.
// Reset (rst, synchronous, active high) returns the controller to idle and drops result valid.
`default_nettype none
module gregorian_date_add_subtract_days #(
  parameter int COUNT_BITS = 16
) (
  input wire            clk,
  input wire            rst,
  gdas_item_if.sink     item,
  gdas_result_if.source result
);
  import gdas_pkg::*;
  `include "gregorian_date_add_subtract_days_defines.svh"

  item_t      item_payload;
  result_t    result_payload;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       item_ready;
  logic       result_valid;

  assign item_payload.mode        = item.mode;
  assign item_payload.start_day   = item.start_day;
  assign item_payload.start_month = item.start_month;
  assign item_payload.start_year  = item.start_year;
  assign item_payload.day_count   = item.day_count;
  assign item.ready               = item_ready;

  assign result.valid        = result_valid;
  assign result.result_day   = result_payload.result_day;
  assign result.result_month = result_payload.result_month;
  assign result.result_year  = result_payload.result_year;
  assign result.out_of_range = result_payload.out_of_range;

  gdas_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  gdas_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item_payload),
    .cmd          (cmd),
    .status       (status),
    .result       (result_payload),
    .result_valid (result_valid),
    .result_ready (result.ready)
  );

  // a pending result is never overwritten
  `GDAS_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.load_out, !result.valid || result.ready,
                   "result register loaded while a result is stalled")
  // busy from the transaction until the result is loaded into the output register
  `GDAS_ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready,
                    "new item accepted while a walk is running")
  `GDAS_ASSERT_NEXT(a_load_shows, clk, rst, cmd.load_out, result.valid,
                    "loaded result not presented")
  `GDAS_ASSERT_NEXT(a_taken_clears, clk, rst,
                    result.valid && result.ready && !cmd.load_out, !result.valid,
                    "result repeated after its transaction")

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import gdas_pkg::*;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_SUB = 1'b1;
  localparam int   RANDOM_ITEMS = 270;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_SQUARE} rx_style_t;

  class date_scoreboard;
    result_t     expected_dates[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function bit leap_year(int y);
      int r400;
      r400 = ((y % 400) + 400) % 400;
      return (r400 == 0) || ((r400 % 4 == 0) && (r400 % 100 != 0));
    endfunction

    static function int unsigned days_in_month(int unsigned m, int y);
      if (m == FEB) return leap_year(y) ? 29 : 28;
      if (m == APR || m == JUN || m == SEP || m == NOV) return 30;
      return 31;
    endfunction

    // walks one month at a time on an unbounded year, then saturates
    static function result_t shift_date(item_t it);
      int unsigned day;
      int unsigned month;
      int unsigned len;
      int unsigned left;
      int          year;
      result_t     r;
      day   = it.start_day;
      month = it.start_month;
      year  = int'(it.start_year);
      if (month == 0) month = JAN;
      if (month > DEC) month = DEC;
      if (day == 0) day = 1;
      len = days_in_month(month, year);
      if (day > len) day = len;
      if (it.mode == MODE_ADD) begin
        left = day + it.day_count;
        while (1) begin
          len = days_in_month(month, year);
          if (left <= len) break;
          left -= len;
          month++;
          if (month == MONTH_WRAP) begin
            month = JAN;
            year++;
          end
        end
        day = left;
      end else begin
        left = it.day_count;
        while (day <= left) begin
          left -= day;
          month--;
          if (month == 0) begin
            month = DEC;
            year--;
          end
          day = days_in_month(month, year);
        end
        day -= left;
      end
      r.result_day   = DAY_W'(day);
      r.result_month = MONTH_W'(month);
      r.out_of_range = 1'b1;
      if (year < int'(YEAR_MIN)) r.result_year = YEAR_IN_W'(YEAR_MIN);
      else if (year > int'(YEAR_MAX)) r.result_year = YEAR_IN_W'(YEAR_MAX);
      else begin
        r.result_year  = YEAR_IN_W'(year);
        r.out_of_range = 1'b0;
      end
      return r;
    endfunction

    function void note_item(item_t it);
      expected_dates.push_back(shift_date(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      bad;
      if (expected_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: %0d-%0d-%0d oor=%0b",
                   got.result_year, got.result_month, got.result_day, got.out_of_range);
        return;
      end
      want = expected_dates.pop_front();
      bad = (got.result_day !== want.result_day) || (got.result_month !== want.result_month) ||
            (got.result_year !== want.result_year) ||
            (got.out_of_range !== want.out_of_range);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %0d-%0d-%0d oor=%0b, got %0d-%0d-%0d oor=%0b",
                   want.result_year, want.result_month, want.result_day, want.out_of_range,
                   got.result_year, got.result_month, got.result_day, got.out_of_range);
      end
    endfunction

    function int unsigned outstanding();
      return expected_dates.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (expected_dates.size() == 0);
    endfunction
  endclass

  logic clk;
  logic rst;
  gdas_item_if   item_ch();
  gdas_result_if res_ch();

  gregorian_date_add_subtract_days #(.COUNT_BITS(16)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  date_scoreboard sb;
  int             burst_left;
  logic [31:0]    rx_cycle = '0;
  rx_style_t      rx_style = RX_ALWAYS;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // transaction monitors
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready)
      sb.note_item('{item_ch.mode, item_ch.start_day, item_ch.start_month,
                     item_ch.start_year, item_ch.day_count});
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result('{res_ch.result_day, res_ch.result_month, res_ch.result_year,
                        res_ch.out_of_range});
  end

  // receiver back-pressure, style re-picked at random whenever rx_cycle[6:0] is zero
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[6:0] == '0) rx_style <= rx_style_t'($urandom_range(0, 3));
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS: res_ch.ready <= 1'b1;
        RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   res_ch.ready <= rx_cycle[2];
      endcase
    end
  end

  function automatic item_t date_item(logic mode, int day, int month, int year, int count);
    item_t it;
    it.mode        = mode;
    it.start_day   = DAY_W'(day);
    it.start_month = MONTH_W'(month);
    it.start_year  = YEAR_IN_W'(year);
    it.day_count   = DAY_COUNT_W'(count);
    return it;
  endfunction

  function automatic item_t random_date_item();
    int sel;
    int year;
    int count;
    sel = $urandom_range(0, 99);
    if (sel < 70) year = $urandom_range(1, 9999);
    else if (sel < 78) year = $urandom_range(1, 200);
    else if (sel < 85) year = $urandom_range(9800, 9999);
    else year = $urandom_range(0, 16383);
    // mostly short walks, a few across the full count range
    sel = $urandom_range(0, 99);
    if (sel < 55) count = $urandom_range(0, 400);
    else if (sel < 85) count = $urandom_range(0, 4000);
    else if (sel < 95) count = $urandom_range(0, 20000);
    else count = $urandom_range(0, 65535);
    return date_item(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                     ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 15),
                     year, count);
  endfunction

  task automatic drive_item(input item_t it);
    item_ch.valid       <= 1'b1;
    item_ch.mode        <= it.mode;
    item_ch.start_day   <= it.start_day;
    item_ch.start_month <= it.start_month;
    item_ch.start_year  <= it.start_year;
    item_ch.day_count   <= it.day_count;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // n must be at least 1 so that valid is never lowered and raised in one step
  task automatic idle_sender(input int n);
    item_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_paced(input item_t it);
    drive_item(it);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 9) >= 3) idle_sender($urandom_range(1, 15));
    end
  endtask

  task automatic drain_results();
    while (sb.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    item_t directed[$];
    sb = new();
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.mode        = MODE_ADD;
    item_ch.start_day   = '0;
    item_ch.start_month = '0;
    item_ch.start_year  = '0;
    item_ch.day_count   = '0;
    burst_left          = $urandom_range(1, 12);

    directed.push_back(date_item(MODE_ADD, 31, 12, 1999, 1));
    directed.push_back(date_item(MODE_SUB, 1, 1, 2000, 1));
    directed.push_back(date_item(MODE_ADD, 28, 2, 2000, 1));
    directed.push_back(date_item(MODE_ADD, 28, 2, 1900, 1));
    directed.push_back(date_item(MODE_ADD, 28, 2, 2004, 1));
    directed.push_back(date_item(MODE_SUB, 1, 3, 2100, 1));
    directed.push_back(date_item(MODE_ADD, 0, 0, 2023, 0));
    directed.push_back(date_item(MODE_SUB, 31, 15, 9999, 0));
    directed.push_back(date_item(MODE_ADD, 31, 2, 2001, 0));
    directed.push_back(date_item(MODE_ADD, 30, 2, 2000, 5));
    directed.push_back(date_item(MODE_SUB, 1, 1, 1, 1));
    directed.push_back(date_item(MODE_ADD, 31, 12, 9999, 1));
    directed.push_back(date_item(MODE_ADD, 29, 2, 0, 0));
    directed.push_back(date_item(MODE_ADD, 31, 15, 16383, 65535));
    directed.push_back(date_item(MODE_SUB, 31, 12, 0, 65535));
    directed.push_back(date_item(MODE_SUB, 31, 12, 16383, 65535));
    directed.push_back(date_item(MODE_ADD, 1, 1, 1, 65535));
    directed.push_back(date_item(MODE_SUB, 31, 12, 9999, 65535));
    directed.push_back(date_item(MODE_SUB, 31, 3, 2023, 31));
    directed.push_back(date_item(MODE_SUB, 31, 3, 2023, 30));
    directed.push_back(date_item(MODE_ADD, 31, 1, 2024, 29));
    directed.push_back(date_item(MODE_SUB, 0, 13, 500, 400));
    directed.push_back(date_item(MODE_ADD, 31, 4, 1600, 1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_paced(directed[i]);
    // hold the sender until the block has fully drained
    idle_sender(1);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) send_paced(random_date_item());
    idle_sender(1);
    drain_results();
    repeat (40) @(posedge clk);

    if (sb.clean()) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
